// ===== design/vrbo_pkg.sv =====
// Shared types and constants for the view ray box occlusion test.
// Used by vrbo_axis and view_ray_box_occlusion_test; depends on nothing.
package vrbo_pkg;

	localparam int COORD_FRAC_BITS = 8;
	localparam int COORD_W = 24;
	localparam int REL_W = COORD_W + 1;
	localparam int HALF_W = 16;
	localparam int SLAB_W = COORD_W + 4;
	localparam int RAD_W = 23;
	localparam int TAG_W = 16;
	localparam int TILE_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W = SLAB_W + COORD_W + 1;

	localparam logic [HALF_W-1:0] TREE_HALF = HALF_W'(1) << COORD_FRAC_BITS;

	localparam logic ACT_BUILDING = 1'b0;
	localparam logic ACT_TREE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_RADIUS = 3'd4;

	localparam logic [RAD_W-1:0] VIEW_RADIUS_RESET = RAD_W'(7680);

	// Per-axis slab span as entry/exit numerators over a shared denominator
	typedef struct packed {
		logic signed [SLAB_W-1:0] lo;
		logic signed [SLAB_W-1:0] hi;
		logic [COORD_W-1:0] den;
		logic active;
		logic miss;
	} axis_t;

endpackage

// ===== design/vrbo_axis.sv =====
// Slab numerators for one axis of the camera to player segment.
// Depends on vrbo_pkg.
module vrbo_axis (
	input logic signed [vrbo_pkg::COORD_W-1:0] cam,
	input logic signed [vrbo_pkg::REL_W-1:0] rel,
	input logic [vrbo_pkg::HALF_W-1:0] half,
	output vrbo_pkg::axis_t axis
);
	import vrbo_pkg::*;

	logic signed [SLAB_W-1:0] d;
	logic signed [SLAB_W-1:0] h;
	logic signed [SLAB_W-1:0] sum_dh;
	logic signed [SLAB_W-1:0] dif_dh;
	logic signed [SLAB_W-1:0] neg_sum;
	logic signed [SLAB_W-1:0] neg_dif;
	logic signed [COORD_W:0] cam_neg;

	// Offset of box centre from camera, and the box half extent
	assign d = SLAB_W'(rel) - SLAB_W'(cam);
	assign h = $signed({{(SLAB_W-HALF_W){1'b0}}, half});
	assign sum_dh = d + h;
	assign dif_dh = d - h;
	assign neg_sum = -sum_dh;
	assign neg_dif = -dif_dh;
	assign cam_neg = -(COORD_W+1)'(cam);

	// Order the two crossings by direction of travel
	always_comb begin
		axis.active = (cam != '0);
		axis.miss = (cam == '0) && ((dif_dh > 0) || (sum_dh < 0));
		if (cam < 0) begin
			axis.lo = dif_dh;
			axis.hi = sum_dh;
			axis.den = cam_neg[COORD_W-1:0];
		end else begin
			axis.lo = neg_sum;
			axis.hi = neg_dif;
			axis.den = cam;
		end
	end

endmodule

// ===== design/view_ray_box_occlusion_test.sv =====
// Top level of the view ray box occlusion test: four-stage pipeline.
// Depends on vrbo_pkg and vrbo_axis.
//
// Usage:
//   Configuration: write camera_x, camera_z, player_x, player_y, view_radius
//   through cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write only
//   while no request is in flight.
//   Input: one scene object per request on in_valid/in_ready.
//   Output: one result per request on out_valid/out_ready, in order.
//   Path: an accepted request moves through stages s1..s3 and then the
//   output register, where out_valid rises and the result can be taken.
//   Throughput: one request per cycle while the output is not stalled; set by
//   the single pipeline that moves all four stages together.
//   Stall: when the output register holds an untaken result, the whole
//   pipeline holds and in_ready drops; nothing is lost or repeated.
//   Reset: arst_n clears all valid bits and loads the register defaults
//   (view_radius 30.0, others zero).
module view_ray_box_occlusion_test (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [vrbo_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [vrbo_pkg::COORD_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic action,
	input logic [vrbo_pkg::TAG_W-1:0] object_tag,
	input logic signed [vrbo_pkg::COORD_W-1:0] world_x,
	input logic signed [vrbo_pkg::COORD_W-1:0] world_y,
	input logic [vrbo_pkg::HALF_W-1:0] half_width,
	input logic [vrbo_pkg::HALF_W-1:0] half_depth,
	output logic out_valid,
	input logic out_ready,
	output logic occluded,
	output logic [vrbo_pkg::TAG_W-1:0] tag_out,
	output logic signed [vrbo_pkg::TILE_W-1:0] tile_x,
	output logic signed [vrbo_pkg::TILE_W-1:0] tile_y
);
	import vrbo_pkg::*;

	localparam logic [REL_W-1:0] ROUND_HALF = REL_W'(1) << (COORD_FRAC_BITS - 1);

	logic signed [COORD_W-1:0] camera_x_q, camera_z_q, player_x_q, player_y_q;
	logic [RAD_W-1:0] view_radius_q;

	logic adv;

	// stage 1
	logic v_s1;
	logic signed [REL_W-1:0] rx_s1, rz_s1;
	logic [HALF_W-1:0] hw_s1, hd_s1;
	logic [COORD_W-1:0] rad_s1;
	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3;
	logic [TILE_W-1:0] tx_s1, ty_s1, tx_s2, ty_s2, tx_s3, ty_s3;

	// stage 2
	logic v_s2;
	logic [2*REL_W-2:0] sqx_s2, sqz_s2;
	logic [2*COORD_W-1:0] rsq_s2;
	axis_t ax_s2, az_s2;

	// stage 3
	logic v_s3;
	logic inr_s3, okx_s3, okz_s3, both_s3, any_s3;
	logic signed [PROD_W-1:0] pa_s3, pb_s3, pc_s3, pd_s3;

	// combinational
	logic [HALF_W-1:0] hw_c, hd_c;
	logic [TILE_W-1:0] tx_c, ty_c;
	axis_t ax_c, az_c;
	logic signed [2*REL_W-1:0] sqx_c, sqz_c;
	logic [2*COORD_W-1:0] rsq_c;
	logic [2*REL_W-1:0] d2_c;

	// Round half away from zero, keep the low tile bits
	function automatic logic [TILE_W-1:0] round_tile(input logic signed [COORD_W-1:0] v);
		logic [REL_W-1:0] mag;
		logic [REL_W-1:0] rnd;
		logic [REL_W-1:0] neg;
		mag = (v < 0) ? REL_W'(-REL_W'(v)) : REL_W'(v);
		rnd = (mag + ROUND_HALF) >> COORD_FRAC_BITS;
		neg = -rnd;
		round_tile = (v < 0) ? neg[TILE_W-1:0] : rnd[TILE_W-1:0];
	endfunction

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_x_q <= '0;
			camera_z_q <= '0;
			player_x_q <= '0;
			player_y_q <= '0;
			view_radius_q <= VIEW_RADIUS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CAMERA_X: camera_x_q <= cfg_data;
				REG_CAMERA_Z: camera_z_q <= cfg_data;
				REG_PLAYER_X: player_x_q <= cfg_data;
				REG_PLAYER_Y: player_y_q <= cfg_data;
				REG_VIEW_RADIUS: view_radius_q <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Whole pipeline advances unless the output holds an untaken result
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	assign hw_c = (action == ACT_TREE) ? TREE_HALF : half_width;
	assign hd_c = (action == ACT_TREE) ? TREE_HALF : half_depth;
	assign tx_c = round_tile(world_x);
	assign ty_c = round_tile(world_y);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid <= v_s3;
		end
	end

	// Stage 1: place object relative to player, pick extents, round tiles
	always_ff @(posedge clk) begin
		if (adv) begin
			rx_s1 <= REL_W'(world_x) - REL_W'(player_x_q);
			rz_s1 <= REL_W'(world_y) - REL_W'(player_y_q);
			hw_s1 <= hw_c;
			hd_s1 <= hd_c;
			rad_s1 <= COORD_W'(view_radius_q) + COORD_W'(hw_c);
			tag_s1 <= object_tag;
			tx_s1 <= tx_c;
			ty_s1 <= ty_c;
		end
	end

	vrbo_axis u_axis_x (.cam(camera_x_q), .rel(rx_s1), .half(hw_s1), .axis(ax_c));
	vrbo_axis u_axis_z (.cam(camera_z_q), .rel(rz_s1), .half(hd_s1), .axis(az_c));

	assign sqx_c = rx_s1 * rx_s1;
	assign sqz_c = rz_s1 * rz_s1;
	assign rsq_c = rad_s1 * rad_s1;

	// Stage 2: squares for the range test, slab numerators
	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2 <= sqx_c[2*REL_W-2:0];
			sqz_s2 <= sqz_c[2*REL_W-2:0];
			rsq_s2 <= rsq_c;
			ax_s2 <= ax_c;
			az_s2 <= az_c;
			tag_s2 <= tag_s1;
			tx_s2 <= tx_s1;
			ty_s2 <= ty_s1;
		end
	end

	assign d2_c = (2*REL_W)'(sqx_s2) + (2*REL_W)'(sqz_s2);

	// Stage 3: range compare, single-axis checks, cross products
	always_ff @(posedge clk) begin
		if (adv) begin
			inr_s3 <= d2_c <= (2*REL_W)'(rsq_s2);
			okx_s3 <= ax_s2.active ? ((ax_s2.hi >= 0) &&
				(ax_s2.lo <= $signed({{(SLAB_W-COORD_W){1'b0}}, ax_s2.den})))
				: !ax_s2.miss;
			okz_s3 <= az_s2.active ? ((az_s2.hi >= 0) &&
				(az_s2.lo <= $signed({{(SLAB_W-COORD_W){1'b0}}, az_s2.den})))
				: !az_s2.miss;
			both_s3 <= ax_s2.active && az_s2.active;
			any_s3 <= ax_s2.active || az_s2.active;
			pa_s3 <= ax_s2.lo * $signed({1'b0, az_s2.den});
			pb_s3 <= az_s2.hi * $signed({1'b0, ax_s2.den});
			pc_s3 <= az_s2.lo * $signed({1'b0, ax_s2.den});
			pd_s3 <= ax_s2.hi * $signed({1'b0, az_s2.den});
			tag_s3 <= tag_s2;
			tx_s3 <= tx_s2;
			ty_s3 <= ty_s2;
		end
	end

	// Stage 4: combine into the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			occluded <= inr_s3 && any_s3 && okx_s3 && okz_s3 &&
				(!both_s3 || (!(pa_s3 > pb_s3) && !(pc_s3 > pd_s3)));
			tag_out <= tag_s3;
			tile_x <= tx_s3;
			tile_y <= ty_s3;
		end
	end

endmodule
